FILE: src/scp_pkg.sv
`default_nettype none

package scp_pkg;

	// Frame length default (bytes per frame, newline included on the setting channel)
	localparam int FRAME_LENGTH_DEF = 6;

	// Reply codes
	localparam logic [7:0] ACK    = 8'h06;
	localparam logic [7:0] NAK    = 8'h15;
	localparam logic [7:0] PROMPT = 8'h04;

	// Characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_V     = 8'h56;

	// Setting limits
	localparam logic [7:0] MODE_MAX      = 8'd2;
	localparam logic [7:0] INTERVAL_MIN  = 8'd15;
	localparam logic [7:0] INTERVAL_MAX  = 8'd60;
	localparam logic [7:0] AMPLITUDE_MAX = 8'd99;
	localparam logic [7:0] PRECHARGE_MAX = 8'd1;

	// Input channel selector
	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		PARAM_MD,
		PARAM_II,
		PARAM_VA,
		PARAM_PR,
		PARAM_NONE
	} param_t;

	typedef struct packed {
		logic       precharge;
		logic [6:0] amplitude;
		logic [5:0] interval;
		logic [1:0] mode;
	} settings_t;

	// Up to three reply bytes, data[0] goes out first
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] data;
	} reply_t;

	typedef struct packed {
		logic       mode_we;
		logic       interval_we;
		logic       amplitude_we;
		logic       precharge_we;
		logic [7:0] value;
	} update_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic param_t param_code(input logic [7:0] p0, input logic [7:0] p1);
		param_t code;
		priority if (p0 == CH_M && p1 == CH_D) code = PARAM_MD;
		else if (p0 == CH_I && p1 == CH_I) code = PARAM_II;
		else if (p0 == CH_V && p1 == CH_A) code = PARAM_VA;
		else if (p0 == CH_P && p1 == CH_R) code = PARAM_PR;
		else code = PARAM_NONE;
		return code;
	endfunction

	// Two-character integer decode: skip blanks, optional sign, digits, wraps mod 256
	function automatic logic [7:0] decode_value(input logic [7:0] c0, input logic [7:0] c1);
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] res;
		d0  = c0 - CH_ZERO;
		d1  = c1 - CH_ZERO;
		res = 8'd0;
		priority if (is_ws(c0)) begin
			if (is_digit(c1)) res = d1;
		end else if (c0 == CH_PLUS) begin
			if (is_digit(c1)) res = d1;
		end else if (c0 == CH_MINUS) begin
			if (is_digit(c1)) res = 8'd0 - d1;
		end else if (is_digit(c0)) begin
			if (is_digit(c1)) res = 8'(d0 * 8'd10 + d1);
			else res = d0;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: src/serial_setting_command_parser.sv
// Serial setting command parser. Each input item is one received byte; s_tuser selects the
// setting channel (0) or the query channel (1), and each channel collects its own frame of
// FRAME_LENGTH bytes (bytes 1-2 parameter letters MD/II/VA/PR, bytes 3-4 two-character
// decimal value, final byte newline on the setting channel). Non-final setting bytes answer
// 0x04; a complete setting frame is range-checked and answered with ACK (0x06) or NAK (0x15)
// plus, for some errors, the letters or the value; a complete query frame answers ACK and the
// stored value, or NAK. An item yields zero to three reply items; m_tlast marks the last one,
// and every reply item also carries the current settings. Each item passes through the input
// register and then the reply buffer before its first reply byte appears. Throughput is one
// item per cycle for items with at most one reply byte while m_tready is high; an item with
// more reply bytes holds the input until the single-byte output port drains the reply buffer.
`default_nettype none

module serial_setting_command_parser #(
	parameter int FRAME_LENGTH = scp_pkg::FRAME_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  wire logic        s_tuser,  // [0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // [7:0] tx_byte, [9:8] mode_now, [15:10] interval_now,
	                                   // [22:16] amplitude_now, [23] precharge_now
	output logic             m_tlast   // last_byte
);
	import scp_pkg::*;

	localparam int                FILL_W = $clog2(FRAME_LENGTH);
	localparam logic [FILL_W-1:0] LAST   = FILL_W'(FRAME_LENGTH - 1);

	logic              valid_s1;
	logic              opcode_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              reply_free;
	logic [FILL_W-1:0] set_fill_q;
	logic [FILL_W-1:0] query_fill_q;
	logic [3:0][7:0]   set_frame_q;
	logic [1:0][7:0]   query_frame_q;
	settings_t         settings_q;
	logic              set_final;
	logic              query_final;
	reply_t            reply_d;
	update_t           update_d;
	logic [7:0]        tx_byte;

	assign set_final   = (set_fill_q >= LAST);
	assign query_final = (query_fill_q >= LAST);
	assign advance     = valid_s1 && reply_free;
	assign s_tready    = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	// fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_fill_q   <= '0;
			query_fill_q <= '0;
		end else if (advance) begin
			if (opcode_s1 == OP_SET) begin
				set_fill_q <= set_final ? '0 : set_fill_q + FILL_W'(1);
			end else begin
				query_fill_q <= query_final ? '0 : query_fill_q + FILL_W'(1);
			end
		end
	end

	// frame bytes that matter: letters and value characters
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (advance && opcode_s1 == OP_SET && !set_final && set_fill_q == FILL_W'(k + 1))
				set_frame_q[k] <= byte_s1;
		end
		for (int k = 0; k < 2; k++) begin
			if (advance && opcode_s1 == OP_QUERY && !query_final &&
					query_fill_q == FILL_W'(k + 1))
				query_frame_q[k] <= byte_s1;
		end
	end

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_q <= '0;
		end else if (advance) begin
			if (update_d.mode_we)      settings_q.mode      <= update_d.value[1:0];
			if (update_d.interval_we)  settings_q.interval  <= update_d.value[5:0];
			if (update_d.amplitude_we) settings_q.amplitude <= update_d.value[6:0];
			if (update_d.precharge_we) settings_q.precharge <= update_d.value[0];
		end
	end

	scp_exec u_exec (
		.opcode      (opcode_s1),
		.rx_byte     (byte_s1),
		.set_final   (set_final),
		.query_final (query_final),
		.set_bytes   (set_frame_q),
		.query_bytes (query_frame_q),
		.cur         (settings_q),
		.reply       (reply_d),
		.update      (update_d)
	);

	scp_reply u_reply (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.reply_in (reply_d),
		.ready    (m_tready),
		.valid    (m_tvalid),
		.data     (tx_byte),
		.last     (m_tlast),
		.free     (reply_free)
	);

	// settings shown are those after the item; the next item commits only as the last byte leaves
	assign m_tdata = {settings_q.precharge, settings_q.amplitude, settings_q.interval,
		settings_q.mode, tx_byte};

	// fill counters never pass the final position
	assert property (@(posedge clk) disable iff (!arst_n) set_fill_q <= LAST)
		else $error("set fill beyond final position");
	assert property (@(posedge clk) disable iff (!arst_n) query_fill_q <= LAST)
		else $error("query fill beyond final position");
	// a waiting item is not dropped
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 && !advance |=> valid_s1)
		else $error("input stage lost an item");
	// every setting byte is answered
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && opcode_s1 == OP_SET |-> reply_d.cnt != 2'd0)
		else $error("setting byte without reply");
	// a silent item leaves the output idle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && reply_d.cnt == 2'd0 |=> !m_tvalid)
		else $error("reply from a silent item");

endmodule

`default_nettype wire

FILE: src/scp_exec.sv
`default_nettype none

// Decodes one registered item against the frame state and builds its reply
module scp_exec (
	input  wire logic               opcode,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               set_final,
	input  wire logic               query_final,
	input  wire logic [3:0][7:0]    set_bytes,   // frame bytes 1..4
	input  wire logic [1:0][7:0]    query_bytes, // frame bytes 1..2
	input  wire scp_pkg::settings_t cur,
	output scp_pkg::reply_t         reply,
	output scp_pkg::update_t        update
);
	import scp_pkg::*;

	logic [7:0] value;
	param_t     set_param;
	param_t     query_param;

	assign value       = decode_value(set_bytes[2], set_bytes[3]);
	assign set_param   = param_code(set_bytes[0], set_bytes[1]);
	assign query_param = param_code(query_bytes[0], query_bytes[1]);

	always_comb begin
		reply        = '0;
		update       = '0;
		update.value = value;
		if (opcode == OP_SET) begin
			// setting channel
			priority if (!set_final) begin
				reply.cnt     = 2'd1;
				reply.data[0] = PROMPT;
			end else if (rx_byte != CH_LF) begin
				reply.cnt     = 2'd1;
				reply.data[0] = NAK;
			end else begin
				unique case (set_param)
					PARAM_MD: begin
						reply.cnt      = 2'd1;
						update.mode_we = (value <= MODE_MAX);
						reply.data[0]  = update.mode_we ? ACK : NAK;
					end
					PARAM_II: begin
						update.interval_we = (value >= INTERVAL_MIN) && (value <= INTERVAL_MAX);
						reply.data[0]      = update.interval_we ? ACK : NAK;
						reply.data[1]      = set_bytes[0];
						reply.data[2]      = set_bytes[1];
						reply.cnt          = update.interval_we ? 2'd1 : 2'd3;
					end
					PARAM_VA: begin
						reply.cnt           = 2'd1;
						update.amplitude_we = (value <= AMPLITUDE_MAX);
						reply.data[0]       = update.amplitude_we ? ACK : NAK;
					end
					PARAM_PR: begin
						update.precharge_we = (value <= PRECHARGE_MAX);
						reply.data[0]       = update.precharge_we ? ACK : NAK;
						reply.data[1]       = value;
						reply.cnt           = update.precharge_we ? 2'd1 : 2'd2;
					end
					default: begin
						reply.cnt     = 2'd3;
						reply.data[0] = NAK;
						reply.data[1] = set_bytes[0];
						reply.data[2] = set_bytes[1];
					end
				endcase
			end
		end else if (query_final) begin
			// query channel, complete frame
			unique case (query_param)
				PARAM_MD: begin
					reply.cnt     = 2'd2;
					reply.data[0] = ACK;
					reply.data[1] = {6'd0, cur.mode};
				end
				PARAM_II: begin
					reply.cnt     = 2'd2;
					reply.data[0] = ACK;
					reply.data[1] = {2'd0, cur.interval};
				end
				PARAM_VA: begin
					reply.cnt     = 2'd2;
					reply.data[0] = ACK;
					reply.data[1] = {1'b0, cur.amplitude};
				end
				default: begin
					reply.cnt     = 2'd1;
					reply.data[0] = NAK;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/scp_reply.sv
`default_nettype none

// Reply buffer: holds up to three bytes and sends them one per accepted item
module scp_reply (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire scp_pkg::reply_t reply_in,
	input  wire logic            ready,
	output logic                 valid,
	output logic [7:0]           data,
	output logic                 last,
	output logic                 free
);
	import scp_pkg::*;

	logic [2:0][7:0] data_q;
	logic [1:0]      rem_q;
	logic            pop;

	assign valid = (rem_q != 2'd0);
	assign last  = (rem_q == 2'd1);
	assign data  = data_q[0];
	assign pop   = valid && ready;
	assign free  = !valid || (last && ready);

	// pending byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= reply_in.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// byte queue, shifts toward slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= reply_in.data;
		end else if (pop) begin
			data_q[0] <= data_q[1];
			data_q[1] <= data_q[2];
		end
	end

endmodule

`default_nettype wire
